// ===== rtl/ppdf_pkg.sv =====
// shared types and constants for the parallel port dac fifo
`default_nettype none

package ppdf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 14;

    localparam logic [BYTE_W-1:0] STATUS_FULL = 8'h40;
    localparam logic [BYTE_W-1:0] STATUS_NONE = 8'h00;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_STATUS  = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_CONTROL = 2'd3
    } t_req;

    // per-cycle control broadcast to every queue cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/parallel_port_dac_fifo.sv =====
// top level: parallel port sound device, byte queue of cells feeding an 8-bit dac
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one bus request per transfer:
//   data write pushes i_write_byte unless the queue is full (then it is dropped),
//   status read reports STATUS_FULL when full, sample tick moves the head byte
//   into the dac register unless the queue is empty, control write does nothing.
//   output channel (o_out_valid / i_out_ready) returns one result per request:
//   the status byte and the dac level (dac byte with top bit flipped, times 64).
//   the result is registered: it is valid in the cycle after the input transfer.
//   throughput is one request per cycle while the receiver takes each result; the result register frees in the same
//   cycle it is taken, so a new request is accepted while the old result leaves.
//   the queue is a row of cells that shift toward the head on every tick, so
//   each request updates the whole row at once.
//   when the receiver stalls, the result is held and o_in_ready drops until
//   the result is taken.
//   reset (synchronous, active low) empties the queue, clears the dac byte to
//   zero (level -8192) and drops any pending result. no clearing pass.
`default_nettype none

module parallel_port_dac_fifo
    import ppdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // request channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [BYTE_W-1:0]         i_write_byte,
    // result channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [BYTE_W-1:0]              o_status_byte,
    output logic signed [LEVEL_W-1:0]      o_audio_level
);

    // queue cell row, cell 0 is the head
    logic              w_valid [QUEUE_DEPTH];
    logic [BYTE_W-1:0] w_data  [QUEUE_DEPTH];

    logic       w_accept;
    t_req       w_req;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    logic [BYTE_W-1:0]         r_dac;
    logic [BYTE_W-1:0]         n_dac;
    logic                      r_out_valid;
    logic [BYTE_W-1:0]         r_status;
    logic signed [LEVEL_W-1:0] r_level;
    logic [BYTE_W-1:0]         n_status;

    assign w_req    = t_req'(i_req_type);
    assign w_accept = i_in_valid && o_in_ready;

    // valid bits stay contiguous from the head, so tail and head tell full and empty
    assign w_full  = w_valid[QUEUE_DEPTH-1];
    assign w_empty = !w_valid[0];

    assign w_ctrl.push = w_accept && (w_req == REQ_WRITE) && !w_full;
    assign w_ctrl.pop  = w_accept && (w_req == REQ_TICK) && !w_empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic              w_prev_valid;
        logic              w_next_valid;
        logic [BYTE_W-1:0] w_next_data;

        if (g == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            // nothing behind the tail cell, it empties on pop
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        ppdf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_valid (w_prev_valid),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .i_write_byte (i_write_byte),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g])
        );
    end

    // dac register loads the head byte on a tick
    assign n_dac = w_ctrl.pop ? w_data[0] : r_dac;

    // status reflects the queue before the request
    assign n_status = ((w_req == REQ_STATUS) && w_full) ? STATUS_FULL : STATUS_NONE;

    // result register frees when empty or being taken this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_dac <= n_dac;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, level is the flipped byte as signed times 64
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_level  <= {~n_dac[BYTE_W-1], n_dac[BYTE_W-2:0], 6'b0};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status_byte = r_status;
    assign o_audio_level = r_level;

    // a full tail cell means the head cell is full too
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[QUEUE_DEPTH-1] |-> w_valid[0])
        else $error("queue cells not contiguous");

    // a tick on a non-empty queue loads the old head byte into the dac
    a_tick_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop |=> (r_dac == $past(w_data[0])))
        else $error("dac did not take head byte");

    // a data write to a non-full queue leaves the queue non-empty
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> w_valid[0])
        else $error("push left queue empty");

    // a status read of a full queue reports full
    a_status_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_req == REQ_STATUS) && w_full)
            |=> (o_out_valid && (o_status_byte == STATUS_FULL)))
        else $error("status did not report full");

endmodule

`default_nettype wire

// ===== rtl/ppdf_cell.sv =====
// one queue cell: holds a byte, shifts toward the head on pop, fills at the tail on push
`default_nettype none

module ppdf_cell
    import ppdf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic              i_prev_valid,
    input  wire logic              i_next_valid,
    input  wire logic [BYTE_W-1:0] i_next_data,
    input  wire logic [BYTE_W-1:0] i_write_byte,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_data
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              n_valid;
    logic [BYTE_W-1:0] n_data;
    logic              w_fill;

    // the first empty cell behind a full one takes the pushed byte
    assign w_fill = i_ctrl.push && !r_valid && i_prev_valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (w_fill) begin
            n_valid = 1'b1;
            n_data  = i_write_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== tb/sv/parallel_port_dac_fifo_tb.sv =====
// testbench for the parallel port dac fifo: directed table, then random bus traffic
`timescale 1ns / 100ps

module parallel_port_dac_fifo_tb;
    import ppdf_pkg::*;

    localparam int QDEPTH       = QUEUE_DEPTH_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RANDOM_ITEMS = 1050;
    localparam int BURST_LEN    = 32;
    // cycles with no transfer on either side before the run is called hung
    localparam int HANG_LIMIT   = 4000;
    // result register latency plus some margin for the trailing check
    localparam int TAIL_CYCLES  = 8;

    localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;

    // traffic mixes for the random part
    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    // one returned result: status byte and dac level
    typedef struct packed {
        logic [BYTE_W-1:0]  status;
        logic [LEVEL_W-1:0] level;
    } t_result;

    // one row of the directed table; data steps up by one on each repeat
    typedef struct {
        t_req               req;
        logic [BYTE_W-1:0]  data;
        int                 reps;
        bit                 typed;
        logic [BYTE_W-1:0]  status;
        logic [LEVEL_W-1:0] level;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_req_type = REQ_CONTROL;
    logic [BYTE_W-1:0]         i_write_byte = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [BYTE_W-1:0]         o_status_byte;
    logic signed [LEVEL_W-1:0] o_audio_level;

    // predictor state: bytes waiting in the queue and the dac register
    logic [BYTE_W-1:0] fifo_bytes[$];
    logic [BYTE_W-1:0] dac_now = '0;

    // results owed by the block, oldest first
    t_result pending_results[$];

    int  error_count = 0;
    int  hang_cycles = 0;
    // set during the stretch where neither side idles
    bit  calm = 1'b0;

    t_dir_row dir_rows [0:16];

    always #HALF_PERIOD i_clk = ~i_clk;

    parallel_port_dac_fifo #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_write_byte  (i_write_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status_byte (o_status_byte),
        .o_audio_level (o_audio_level)
    );

    // apply one request to the predicted device and return the result it owes
    function automatic t_result step_device(input t_req req, input logic [BYTE_W-1:0] data);
        t_result r;
        r.status = STATUS_NONE;
        case (req)
            REQ_WRITE: begin
                // a full queue drops the byte
                if (fifo_bytes.size() < QDEPTH)
                    fifo_bytes.push_back(data);
            end
            REQ_STATUS: begin
                if (fifo_bytes.size() == QDEPTH)
                    r.status = STATUS_FULL;
            end
            REQ_TICK: begin
                // empty queue keeps the dac where it is
                if (fifo_bytes.size() != 0)
                    dac_now = fifo_bytes.pop_front();
            end
            default: ;
        endcase
        // flipped byte as signed, times 64, is just the flipped byte shifted up six places
        r.level = {dac_now ^ SIGN_FLIP, 6'b000000};
        return r;
    endfunction

    // request type drawn from the chosen traffic mix
    function automatic t_req pick_req(input t_mix mix);
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
                return roll < 70 ? REQ_WRITE : roll < 85 ? REQ_STATUS :
                       roll < 95 ? REQ_TICK : REQ_CONTROL;
            MIX_DRAIN:
                return roll < 15 ? REQ_WRITE : roll < 30 ? REQ_STATUS :
                       roll < 95 ? REQ_TICK : REQ_CONTROL;
            default:
                return roll < 40 ? REQ_WRITE : roll < 55 ? REQ_STATUS :
                       roll < 90 ? REQ_TICK : REQ_CONTROL;
        endcase
    endfunction

    // offer one request, hold it until the transfer, then log what it owes;
    // a typed expectation replaces the predicted one but the state still moves
    task automatic send_request(input t_req req, input logic [BYTE_W-1:0] data,
                                input bit typed, input t_result typed_result);
        t_result predicted;
        // random gap before the request, one drive per edge
        while (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_write_byte <= data;
        // valid is high from the next edge on, so ready alone marks the transfer
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_device(req, data);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // hold the sender off until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result side: random stalls, and each transfer checked against the oldest owed result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing owed: status %0h level %0d",
                       o_status_byte, o_audio_level);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status_byte !== want.status) begin
                    $error("status_byte: expected %0h, got %0h", want.status, o_status_byte);
                    error_count++;
                end
                if (o_audio_level !== want.level) begin
                    $error("audio_level: expected %0d, got %0d",
                           $signed(want.level), o_audio_level);
                    error_count++;
                end
            end
        end
        i_out_ready <= calm || ($urandom_range(99) >= 26);
    end

    // watchdog on cycles where neither channel moves
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            hang_cycles <= 0;
        else if (hang_cycles + 1 >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else
            hang_cycles <= hang_cycles + 1;
    end

    initial begin
        int      counted;
        int      k;
        t_mix    mix;
        t_req    req;
        t_result typed_result;

        // directed table: reset level, empty tick, ignored control, the four
        // corners of the level, a fill to full, a dropped write and the full flag
        dir_rows = '{
            '{REQ_STATUS,  8'h00,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_TICK,    8'hA5,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_CONTROL, 8'hFF,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_WRITE,   8'h80,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_TICK,    8'h00,  1, 1'b1, STATUS_NONE,  14'sd0},
            '{REQ_WRITE,   8'hFF,  1, 1'b1, STATUS_NONE,  14'sd0},
            '{REQ_TICK,    8'h00,  1, 1'b1, STATUS_NONE,  14'sd8128},
            '{REQ_WRITE,   8'h00,  1, 1'b1, STATUS_NONE,  14'sd8128},
            '{REQ_TICK,    8'hFF,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_WRITE,   8'h7F,  1, 1'b1, STATUS_NONE, -14'sd8192},
            '{REQ_TICK,    8'h00,  1, 1'b1, STATUS_NONE, -14'sd64},
            '{REQ_STATUS,  8'hFF,  1, 1'b1, STATUS_NONE, -14'sd64},
            // fill the queue to the brim with stepping bytes
            '{REQ_WRITE,   8'h01, 16, 1'b0, STATUS_NONE,  14'sd0},
            // full: this byte must vanish
            '{REQ_WRITE,   8'hAA,  1, 1'b1, STATUS_NONE, -14'sd64},
            '{REQ_STATUS,  8'h00,  1, 1'b1, STATUS_FULL, -14'sd64},
            '{REQ_CONTROL, 8'h00,  1, 1'b1, STATUS_NONE, -14'sd64},
            '{REQ_TICK,    8'h00,  1, 1'b0, STATUS_NONE,  14'sd0}
        };

        // synchronous reset held low from the start, then released on an edge
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                typed_result.status = dir_rows[r].status;
                typed_result.level  = dir_rows[r].level;
                send_request(dir_rows[r].req, dir_rows[r].data + k[BYTE_W-1:0],
                             dir_rows[r].typed, typed_result);
            end
        end

        // let the directed part settle before random traffic
        drain_results();

        // random part: bursts of one mix at a time so the queue swings
        // between empty and full; every request counts toward the total
        counted = 0;
        mix     = MIX_BALANCED;
        typed_result = '0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % BURST_LEN == 0)
                mix = t_mix'($urandom_range(2));
            // a long stretch with no idling on either side
            calm = (counted >= 400 && counted < 600);
            req  = pick_req(mix);
            send_request(req, 8'($urandom_range(255)), 1'b0, typed_result);
            counted++;
            // sender pauses mid run until nothing is owed
            if (counted == 700)
                drain_results();
        end

        // wait for the last results, then a short tail for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ppdf_pkg.sv
rtl/ppdf_cell.sv
rtl/parallel_port_dac_fifo.sv
tb/sv/parallel_port_dac_fifo_tb.sv
